>>> rtl/aas_pkg.sv
// ----------------------------------------------------------------------------
// aas_pkg
// Shared constants, types and state encoding for the auction assignment
// solver.
// ----------------------------------------------------------------------------
`default_nettype none

package aas_pkg;

  // default sizes
  localparam int MAX_N_DEF      = 64;
  localparam int COST_WIDTH_DEF = 24;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int SIZE_W     = 7;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE = 1'b0,
    CFG_MODE = 1'b1
  } cfg_reg_e;

  // result fields
  localparam int OBJ_W      = 6;
  localparam int ROUND_W    = 32;
  localparam int PRICE_W    = 32;
  localparam int OUT_PAD_W  = 4;
  localparam int OUT_DATA_W = 2 * OBJ_W + ROUND_W + OUT_PAD_W;

  // second-best profit never goes below this
  localparam int signed SECOND_FLOOR = -1000000000;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              min_mode;
  } aas_cfg_t;

  typedef struct packed {
    logic [OBJ_W-1:0]   object_index;
    logic [OBJ_W-1:0]   bidder_index;
    logic [ROUND_W-1:0] round_count;
    logic               last_pair;
  } aas_res_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SQUARE,
    ST_MAX,
    ST_ASGN_INIT,
    ST_ASGN,
    ST_CHECK,
    ST_BID_SEL,
    ST_BID,
    ST_BID_WR,
    ST_RB_INIT,
    ST_RB_RD,
    ST_RB_OBJ,
    ST_RB_WR,
    ST_OUT_RD,
    ST_OUT_SEND
  } aas_state_e;

endpackage

`default_nettype wire

>>> rtl/aas_core.sv
// ----------------------------------------------------------------------------
// aas_core
// Matrix store, auction sequencer and the object / bid memories. Loads words,
// runs the rounds and streams out one (object, owner) pair per object.
// ----------------------------------------------------------------------------
`default_nettype none

module aas_core
  import aas_pkg::*;
#(
  parameter int MAX_N      = MAX_N_DEF,
  parameter int COST_WIDTH = COST_WIDTH_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire signed [COST_WIDTH-1:0] in_cost_i,
  input  wire                         in_last_i,
  input  wire aas_cfg_t               cfg_i,
  output logic                        res_valid_o,
  input  wire                         res_ready_i,
  output aas_res_t                    res_o
);

  localparam int IDX_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int CELLS  = MAX_N * MAX_N;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int NN_W   = ADDR_W + 1;
  localparam int BEN_W  = COST_WIDTH + 1;
  localparam int PW     = ((BEN_W > PRICE_W) ? BEN_W : PRICE_W) + 2;
  localparam int BW     = PW + 2;
  localparam int ENT_W  = IDX_W + PRICE_W;

  // memories
  logic signed [COST_WIDTH-1:0] ben_mem [CELLS];
  logic [ENT_W-1:0]             obj_mem [MAX_N];
  logic [ENT_W-1:0]             bid_mem [MAX_N];

  logic                         ben_we;
  logic [ADDR_W-1:0]            ben_raddr;
  logic signed [COST_WIDTH-1:0] ben_rdata_q;
  logic                         obj_we;
  logic [IDX_W-1:0]             obj_waddr, obj_raddr;
  logic [ENT_W-1:0]             obj_wdata, obj_rdata_q;
  logic                         bid_we;
  logic [ENT_W-1:0]             bid_wdata, bid_rdata_q;

  // control and working registers
  aas_state_e                state_q, state_d;
  logic [NN_W-1:0]           cnt_q, cnt_d;
  logic [NN_W-1:0]           base_q, base_d;
  logic [NN_W-1:0]           nn_q, nn_d;
  logic [CNT_W-1:0]          i_q, i_d;
  logic [CNT_W-1:0]          n_q, n_d;
  logic [CNT_W-1:0]          matched_q, matched_d;
  logic [ADDR_W-1:0]         load_pos_q, load_pos_d;
  logic                      rd_v_q, rd_v_d;
  logic [ADDR_W-1:0]         rd_idx_q, rd_idx_d;
  logic                      mode_q, mode_d;
  logic [ROUND_W-1:0]        rounds_q, rounds_d;
  logic [MAX_N-1:0]          assigned_q, assigned_d;
  logic [MAX_N-1:0]          obj_valid_q, obj_valid_d;
  logic signed [COST_WIDTH-1:0] max_q, max_d;
  logic signed [PW-1:0]      best_q, best_d;
  logic signed [PW-1:0]      second_q, second_d;
  logic signed [BEN_W-1:0]   best_ben_q, best_ben_d;
  logic [IDX_W-1:0]          best_j_q, best_j_d;

  // datapath
  logic [IDX_W-1:0]        rd_j;
  logic signed [BEN_W-1:0] ben_ext, bval;
  logic [PRICE_W-1:0]      price_cur;
  logic signed [PW-1:0]    profit;
  logic signed [BW-1:0]    bid_raw;
  logic [PRICE_W-1:0]      bid_clamped;
  logic [IDX_W-1:0]        rb_target;
  logic [PRICE_W-1:0]      rb_price;
  logic [NN_W-1:0]         bid_addr;

  // benefit store: written on load, read by the scans
  always_ff @(posedge clk_i) begin
    if (ben_we) begin
      ben_mem[load_pos_q] <= in_cost_i;
    end
    ben_rdata_q <= ben_mem[ben_raddr];
  end

  // object price / owner memory
  always_ff @(posedge clk_i) begin
    if (obj_we) begin
      obj_mem[obj_waddr] <= obj_wdata;
    end
    obj_rdata_q <= obj_mem[obj_raddr];
  end

  // standing bid per bidder
  always_ff @(posedge clk_i) begin
    if (bid_we) begin
      bid_mem[i_q[IDX_W-1:0]] <= bid_wdata;
    end
    bid_rdata_q <= bid_mem[i_q[IDX_W-1:0]];
  end

  // profit of the word that came back from the memories
  assign rd_j      = rd_idx_q[IDX_W-1:0];
  assign ben_ext   = BEN_W'(ben_rdata_q);
  assign bval      = mode_q ? (BEN_W'(max_q) - ben_ext) : ben_ext;
  assign price_cur = obj_valid_q[rd_j] ? obj_rdata_q[PRICE_W-1:0] : '0;
  assign profit    = PW'(bval) - $signed(PW'(price_cur));

  // price of best object plus margin plus one, i.e. benefit - second + 1
  assign bid_raw = BW'(best_ben_q) - BW'(second_q) + 1;
  always_comb begin
    if (bid_raw[BW-1]) begin
      bid_clamped = '0;
    end else if (|bid_raw[BW-2:PRICE_W]) begin
      bid_clamped = '1;
    end else begin
      bid_clamped = bid_raw[PRICE_W-1:0];
    end
  end

  assign rb_target = bid_rdata_q[ENT_W-1:PRICE_W];
  assign rb_price  = obj_valid_q[rb_target] ? obj_rdata_q[PRICE_W-1:0] : '0;
  assign bid_addr  = base_q + cnt_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      base_q      <= '0;
      nn_q        <= '0;
      i_q         <= '0;
      n_q         <= '0;
      matched_q   <= '0;
      load_pos_q  <= '0;
      rd_v_q      <= 1'b0;
      rd_idx_q    <= '0;
      mode_q      <= 1'b0;
      rounds_q    <= '0;
      assigned_q  <= '0;
      obj_valid_q <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      base_q      <= base_d;
      nn_q        <= nn_d;
      i_q         <= i_d;
      n_q         <= n_d;
      matched_q   <= matched_d;
      load_pos_q  <= load_pos_d;
      rd_v_q      <= rd_v_d;
      rd_idx_q    <= rd_idx_d;
      mode_q      <= mode_d;
      rounds_q    <= rounds_d;
      assigned_q  <= assigned_d;
      obj_valid_q <= obj_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    max_q      <= max_d;
    best_q     <= best_d;
    second_q   <= second_d;
    best_ben_q <= best_ben_d;
    best_j_q   <= best_j_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    nn_d        = nn_q;
    i_d         = i_q;
    n_d         = n_q;
    matched_d   = matched_q;
    load_pos_d  = load_pos_q;
    rd_v_d      = 1'b0;
    rd_idx_d    = rd_idx_q;
    mode_d      = mode_q;
    rounds_d    = rounds_q;
    assigned_d  = assigned_q;
    obj_valid_d = obj_valid_q;
    max_d       = max_q;
    best_d      = best_q;
    second_d    = second_q;
    best_ben_d  = best_ben_q;
    best_j_d    = best_j_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ben_we      = 1'b0;
    ben_raddr   = cnt_q[ADDR_W-1:0];
    obj_we      = 1'b0;
    obj_waddr   = rb_target;
    obj_wdata   = {i_q[IDX_W-1:0], bid_rdata_q[PRICE_W-1:0]};
    obj_raddr   = cnt_q[IDX_W-1:0];
    bid_we      = 1'b0;
    bid_wdata   = {best_j_q, bid_clamped};

    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ben_we     = 1'b1;
          load_pos_d = (load_pos_q == ADDR_W'(CELLS - 1)) ? '0 : load_pos_q + 1'b1;
          if (in_last_i) begin
            mode_d = cfg_i.min_mode;
            if (cfg_i.size == '0) begin
              n_d = CNT_W'(1);
            end else if (int'(cfg_i.size) > MAX_N) begin
              n_d = CNT_W'(MAX_N);
            end else begin
              n_d = CNT_W'(cfg_i.size);
            end
            state_d = ST_SQUARE;
          end
        end
      end

      ST_SQUARE: begin
        nn_d        = NN_W'(NN_W'(n_q) * NN_W'(n_q));
        cnt_d       = '0;
        rounds_d    = '0;
        obj_valid_d = '0;
        state_d     = ST_MAX;
      end

      // matrix maximum over the loaded cells
      ST_MAX: begin
        if (cnt_q < nn_q) begin
          rd_v_d   = 1'b1;
          rd_idx_d = cnt_q[ADDR_W-1:0];
          cnt_d    = cnt_q + 1'b1;
        end
        if (rd_v_q) begin
          if (rd_idx_q == '0 || ben_rdata_q > max_q) begin
            max_d = ben_rdata_q;
          end
        end
        if (cnt_q == nn_q && !rd_v_q) begin
          state_d = ST_ASGN_INIT;
        end
      end

      ST_ASGN_INIT: begin
        assigned_d = '0;
        matched_d  = '0;
        cnt_d      = '0;
        state_d    = ST_ASGN;
      end

      // mark bidders that own an object
      ST_ASGN: begin
        if (cnt_q < NN_W'(n_q)) begin
          rd_v_d   = 1'b1;
          rd_idx_d = cnt_q[ADDR_W-1:0];
          cnt_d    = cnt_q + 1'b1;
        end
        if (rd_v_q && obj_valid_q[rd_j]) begin
          assigned_d[obj_rdata_q[ENT_W-1:PRICE_W]] = 1'b1;
          matched_d = matched_q + 1'b1;
        end
        if (cnt_q == NN_W'(n_q) && !rd_v_q) begin
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        cnt_d = '0;
        if (matched_q == n_q || rounds_q == '1) begin
          state_d = ST_OUT_RD;
        end else begin
          rounds_d = rounds_q + 1'b1;
          i_d      = '0;
          base_d   = '0;
          state_d  = ST_BID_SEL;
        end
      end

      ST_BID_SEL: begin
        cnt_d = '0;
        if (i_q == n_q) begin
          state_d = ST_RB_INIT;
        end else if (assigned_q[i_q[IDX_W-1:0]]) begin
          i_d    = i_q + 1'b1;
          base_d = base_q + NN_W'(n_q);
        end else begin
          state_d = ST_BID;
        end
      end

      // scan one row: best and second-best profit
      ST_BID: begin
        ben_raddr = bid_addr[ADDR_W-1:0];
        if (cnt_q < NN_W'(n_q)) begin
          rd_v_d   = 1'b1;
          rd_idx_d = cnt_q[ADDR_W-1:0];
          cnt_d    = cnt_q + 1'b1;
        end
        if (rd_v_q) begin
          if (rd_j == '0) begin
            best_d     = profit;
            best_ben_d = bval;
            best_j_d   = '0;
            second_d   = PW'(SECOND_FLOOR);
          end else if (profit > best_q) begin
            second_d   = (best_q > second_q) ? best_q : second_q;
            best_d     = profit;
            best_ben_d = bval;
            best_j_d   = rd_j;
          end else if (profit > second_q) begin
            second_d = profit;
          end
        end
        if (cnt_q == NN_W'(n_q) && !rd_v_q) begin
          state_d = ST_BID_WR;
        end
      end

      ST_BID_WR: begin
        bid_we  = 1'b1;
        i_d     = i_q + 1'b1;
        base_d  = base_q + NN_W'(n_q);
        state_d = ST_BID_SEL;
      end

      // rebuild prices and owners from all standing bids
      ST_RB_INIT: begin
        obj_valid_d = '0;
        i_d         = '0;
        state_d     = ST_RB_RD;
      end

      ST_RB_RD: begin
        state_d = (i_q == n_q) ? ST_ASGN_INIT : ST_RB_OBJ;
      end

      ST_RB_OBJ: begin
        obj_raddr = rb_target;
        state_d   = ST_RB_WR;
      end

      ST_RB_WR: begin
        if (rb_price < bid_rdata_q[PRICE_W-1:0]) begin
          obj_we                 = 1'b1;
          obj_valid_d[rb_target] = 1'b1;
        end
        i_d     = i_q + 1'b1;
        state_d = ST_RB_RD;
      end

      // one pair per object
      ST_OUT_RD: begin
        if (cnt_q == NN_W'(n_q)) begin
          load_pos_d = '0;
          state_d    = ST_LOAD;
        end else begin
          state_d = ST_OUT_SEND;
        end
      end

      ST_OUT_SEND: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_OUT_RD;
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // result word
  always_comb begin
    res_o.object_index = OBJ_W'(cnt_q);
    res_o.bidder_index = obj_valid_q[cnt_q[IDX_W-1:0]] ?
                         OBJ_W'(obj_rdata_q[ENT_W-1:PRICE_W]) : '0;
    res_o.round_count  = rounds_q;
    res_o.last_pair    = (cnt_q == NN_W'(n_q) - 1'b1);
  end

endmodule

`default_nettype wire

>>> rtl/auction_assignment_solver.sv
// ----------------------------------------------------------------------------
// auction_assignment_solver
// Auction solver for the square assignment problem: configuration registers,
// the solver core and the output register.
// ----------------------------------------------------------------------------
// Usage:
//   Matrix words enter on s_axis, one per cycle, row-major (row = bidder,
//   column = object). s_axis_tlast marks the final word and starts a solve.
//   The core then runs the auction and s_axis_tready stays low until the
//   last of the N result words has entered the output register; pairs leave
//   on m_axis object 0 first, and m_axis_tlast marks the pair for object N-1.
//   After the last word the core finds the matrix maximum, then each round
//   runs the owner pass and round check, a row scan through the benefit
//   memory read port for each bidder that bids, a skip for each owning bidder
//   and the rebuild of prices and owners; the output step reads each pair
//   and reads the next only after it is taken. One solve at a time; loading runs
//   at one word per cycle. cfg_we_i writes size_in_use (index 0) or min_mode
//   (index 1); write only while idle. Reset clears control state; the matrix
//   store holds no defined contents until loaded.
//   If m_axis_tready is low while the output register holds a word, it keeps
//   that word and the core waits with the next pair.
// ----------------------------------------------------------------------------
`default_nettype none

module auction_assignment_solver
  import aas_pkg::*;
#(
  parameter int MAX_N      = MAX_N_DEF,
  parameter int COST_WIDTH = COST_WIDTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // tdata: cost_value
  input  wire  [((COST_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire                          s_axis_tlast,
  // tdata: object_index, bidder_index, round_count, zero pad
  output logic [OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic                         m_axis_tlast,
  input  wire                          cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0]        cfg_wdata_i
);

  aas_cfg_t cfg_q;
  aas_res_t res;
  logic     res_valid, res_ready;
  logic     out_valid_q;
  aas_res_t out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size     <= SIZE_RESET;
      cfg_q.min_mode <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIZE: cfg_q.size     <= cfg_wdata_i[SIZE_W-1:0];
        CFG_MODE: cfg_q.min_mode <= cfg_wdata_i[0];
        default:  cfg_q          <= cfg_q;
      endcase
    end
  end

  aas_core #(
    .MAX_N      (MAX_N),
    .COST_WIDTH (COST_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cost_i   ($signed(s_axis_tdata[COST_WIDTH-1:0])),
    .in_last_i   (s_axis_tlast),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.round_count, out_q.bidder_index,
                          out_q.object_index};
  assign m_axis_tlast  = out_q.last_pair;

endmodule

`default_nettype wire

>>> rtl/aas_checker.sv
// ----------------------------------------------------------------------------
// aas_checker
// Port-level checks on the solver: stalls, object order and round count within
// a result run, and the input lockout after the last word of a solve.
// ----------------------------------------------------------------------------
`default_nettype none

module aas_checker
  import aas_pkg::*;
(
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  s_axis_tvalid,
  input wire                  s_axis_tready,
  input wire                  s_axis_tlast,
  input wire [OUT_DATA_W-1:0] m_axis_tdata,
  input wire                  m_axis_tvalid,
  input wire                  m_axis_tready,
  input wire                  m_axis_tlast
);

  logic [OBJ_W-1:0] exp_obj_q;

  // expected object of the next result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_obj_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      exp_obj_q <= m_axis_tlast ? '0 : exp_obj_q + 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  a_obj_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OBJ_W-1:0] == exp_obj_q)
    else $error("objects out of order");

  a_solve_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken after last word");

  a_round_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      !m_axis_tvalid || m_axis_tdata[2*OBJ_W+ROUND_W-1:2*OBJ_W] ==
      $past(m_axis_tdata[2*OBJ_W+ROUND_W-1:2*OBJ_W]))
    else $error("round count changed within a run");

endmodule

bind auction_assignment_solver aas_checker u_aas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
